// ----- sv/pre_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the PageRank edge engine.
// Depends on nothing; the core and the divider import it.
package pre_pkg;

  localparam int NODE_DEPTH = 1024;
  localparam int EDGE_DEPTH = 8192;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
  localparam int NODE_CNT_W = NODE_AW + 1;
  localparam int EDGE_CNT_W = EDGE_AW + 1;
  localparam int FIELD_W    = 10;
  localparam int DEG_W      = 14;
  localparam logic [DEG_W-1:0] DEG_MAX = '1;
  localparam int RANK_W     = 32;
  localparam int Q16_W      = 16;
  localparam int STEP_W     = 16;
  localparam int PROD_W     = Q16_W + RANK_W;
  localparam int BASE_W     = Q16_W + 1;
  localparam int DIV_W      = 32;
  localparam int DSR_W      = 16;
  localparam int OP_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [RANK_W-1:0] RANK_ONE = 32'h0001_0000;

  localparam logic [10:0] RST_NODE_COUNT = 11'd1024;
  localparam logic [15:0] RST_DAMPING    = 16'd55706;
  localparam logic [15:0] RST_TOLERANCE  = 16'd66;
  localparam logic [9:0]  RST_PROBE      = 10'd100;
  localparam logic [15:0] RST_MAX_STEPS  = 16'd1000;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_COUNT = 3'd0,
    REG_DAMPING    = 3'd1,
    REG_TOLERANCE  = 3'd2,
    REG_PROBE      = 3'd3,
    REG_MAX_STEPS  = 3'd4
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_READ,
    ST_BASE_WAIT,
    ST_INIT,
    ST_A_RD,
    ST_A_DIV,
    ST_A_WAIT,
    ST_B_RD,
    ST_B_ADDR,
    ST_B_WR,
    ST_C_RD,
    ST_C_MUL,
    ST_C_WR,
    ST_CHK_MUL,
    ST_CHK
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- sv/pagerank_edge_engine_core.sv -----
`timescale 1ns / 1ps
// Edge-centric PageRank engine: edge, degree, rank and sum memories plus sweep sequencer.
// Depends on pre_pkg, pre_ram and pre_div.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+---------------------------
//  input    | in_op, in_src_node, in_dst_node              | start & !busy
//  result   | out_rank_value, out_step_count, out_converged,| out_strobe, one cycle
//           | out_store_full                               |
//  config   | cfg_index, cfg_wdata                         | cfg_we, no wait
//
// Load: a degree read-modify-write on the source node; a dropped edge skips it.
// Read: the rank is read, then the result is registered and strobed.
// Clear: a degree clearing pass over all NODE_DEPTH entries. Reset runs the same pass
// with busy high. Run: a base divide and an init pass over the N nodes, then per sweep
// one serial divide per node with out-edges, a pass over the edges and a pass over the
// nodes. Results go out on a strobe; the receiver cannot stall them.
module pagerank_edge_engine_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [pre_pkg::OP_W-1:0]             in_op,
  input  logic [pre_pkg::FIELD_W-1:0]          in_src_node,
  input  logic [pre_pkg::FIELD_W-1:0]          in_dst_node,
  output logic                                 out_strobe,
  output logic [pre_pkg::RANK_W-1:0]           out_rank_value,
  output logic [pre_pkg::STEP_W-1:0]           out_step_count,
  output logic                                 out_converged,
  output logic                                 out_store_full,
  input  logic                                 cfg_we,
  input  logic [pre_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pre_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
  import pre_pkg::*;

  localparam int EDGE_DW = 2 * NODE_AW;

  // configuration
  logic [NODE_CNT_W-1:0] cfg_nodes_r;
  logic [Q16_W-1:0]      cfg_damp_r;
  logic [Q16_W-1:0]      cfg_tol_r;
  logic [NODE_AW-1:0]    cfg_probe_r;
  logic [STEP_W-1:0]     cfg_max_r;

  // control
  state_t                state_r, state_nxt;
  logic [NODE_CNT_W-1:0] v_r, v_nxt;
  logic [EDGE_CNT_W-1:0] e_r, e_nxt;
  logic [EDGE_CNT_W-1:0] edge_total_r, edge_total_nxt;
  logic                  overflow_r, overflow_nxt;
  logic [STEP_W-1:0]     steps_r, steps_nxt;
  logic [STEP_W-1:0]     sweep_cnt_r, sweep_cnt_nxt;
  logic                  last_conv_r, last_conv_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // datapath
  logic [BASE_W-1:0]     base_r, base_nxt;
  logic [RANK_W-1:0]     last_r, last_nxt;
  logic [RANK_W-1:0]     now_r, now_nxt;
  logic [PROD_W-1:0]     prod_r, prod_nxt;
  logic [PROD_W-1:0]     tolp_r, tolp_nxt;
  logic [RANK_W-1:0]     diff_r, diff_nxt;
  logic [NODE_AW-1:0]    t_r, t_nxt;
  logic                  skip_r, skip_nxt;
  logic [NODE_AW-1:0]    src_r, src_nxt;
  logic                  rd_ok_r, rd_ok_nxt;
  logic [RANK_W-1:0]     out_rank_r, out_rank_nxt;
  logic [STEP_W-1:0]     out_step_r, out_step_nxt;
  logic                  out_conv_r, out_conv_nxt;
  logic                  out_full_r, out_full_nxt;

  // memory ports
  logic                  edge_we;
  logic [EDGE_AW-1:0]    edge_waddr, edge_raddr;
  logic [EDGE_DW-1:0]    edge_wdata, edge_rdata;
  logic                  deg_we;
  logic [NODE_AW-1:0]    deg_waddr, deg_raddr;
  logic [DEG_W-1:0]      deg_wdata, deg_rdata;
  logic                  rank_we;
  logic [NODE_AW-1:0]    rank_waddr, rank_raddr;
  logic [RANK_W-1:0]     rank_wdata, rank_rdata;
  logic                  sum_we;
  logic [NODE_AW-1:0]    sum_waddr, sum_raddr;
  logic [RANK_W-1:0]     sum_wdata, sum_rdata;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  // helpers
  logic [NODE_CNT_W-1:0] n_cur;
  logic [STEP_W-1:0]     step_lim;
  logic                  probe_ok;
  logic                  accept;
  logic                  v_last;
  logic [NODE_AW-1:0]    v_idx;
  logic [NODE_AW-1:0]    e_src, e_dst;
  logic [RANK_W:0]       acc_b, acc_c;
  logic                  conv;

  assign accept   = start && (state_r == ST_IDLE);
  assign busy     = (state_r != ST_IDLE);

  // nodes in use clamped to 1..NODE_DEPTH; step limit of zero means one
  always_comb begin
    if (cfg_nodes_r == '0) begin
      n_cur = NODE_CNT_W'(1);
    end else if (32'(cfg_nodes_r) > NODE_DEPTH) begin
      n_cur = NODE_CNT_W'(NODE_DEPTH);
    end else begin
      n_cur = cfg_nodes_r;
    end
  end

  assign step_lim = (cfg_max_r == '0) ? STEP_W'(1) : cfg_max_r;
  assign probe_ok = {1'b0, cfg_probe_r} < n_cur;
  assign v_idx    = v_r[NODE_AW-1:0];
  assign v_last   = (v_r == n_cur - NODE_CNT_W'(1));
  assign e_src    = edge_rdata[EDGE_DW-1:NODE_AW];
  assign e_dst    = edge_rdata[NODE_AW-1:0];
  assign acc_b    = (RANK_W+1)'(sum_rdata) + (RANK_W+1)'(rank_rdata);
  assign acc_c    = (RANK_W+1)'(base_r) + (RANK_W+1)'(prod_r[PROD_W-1:Q16_W]);
  assign conv     = probe_ok && ({diff_r, {Q16_W{1'b0}}} <= tolp_r);

  always_comb begin
    state_nxt      = state_r;
    v_nxt          = v_r;
    e_nxt          = e_r;
    edge_total_nxt = edge_total_r;
    overflow_nxt   = overflow_r;
    steps_nxt      = steps_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    last_conv_nxt  = last_conv_r;
    out_valid_nxt  = 1'b0;
    base_nxt       = base_r;
    last_nxt       = last_r;
    now_nxt        = now_r;
    prod_nxt       = prod_r;
    tolp_nxt       = tolp_r;
    diff_nxt       = diff_r;
    t_nxt          = t_r;
    skip_nxt       = skip_r;
    src_nxt        = src_r;
    rd_ok_nxt      = rd_ok_r;
    out_rank_nxt   = out_rank_r;
    out_step_nxt   = out_step_r;
    out_conv_nxt   = out_conv_r;
    out_full_nxt   = out_full_r;

    edge_we    = 1'b0;
    edge_waddr = edge_total_r[EDGE_AW-1:0];
    edge_wdata = {in_src_node, in_dst_node};
    edge_raddr = e_r[EDGE_AW-1:0];
    deg_we     = 1'b0;
    deg_waddr  = v_idx;
    deg_wdata  = '0;
    deg_raddr  = v_idx;
    rank_we    = 1'b0;
    rank_waddr = v_idx;
    rank_wdata = RANK_ONE;
    rank_raddr = v_idx;
    sum_we     = 1'b0;
    sum_waddr  = v_idx;
    sum_wdata  = '0;
    sum_raddr  = v_idx;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(rank_rdata);
    div_req.divisor  = DSR_W'(deg_rdata);

    unique case (state_r)
      // sweep zeros through the degree memory
      ST_CLEAR: begin
        deg_we = 1'b1;
        v_nxt  = v_r + NODE_CNT_W'(1);
        if (v_r == NODE_CNT_W'(NODE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          unique case (op_t'(in_op))
            OP_LOAD: begin
              if (32'(edge_total_r) >= EDGE_DEPTH || 32'(in_src_node) >= NODE_DEPTH ||
                  32'(in_dst_node) >= NODE_DEPTH) begin
                overflow_nxt = 1'b1;
              end else begin
                edge_we        = 1'b1;
                edge_total_nxt = edge_total_r + EDGE_CNT_W'(1);
                deg_raddr      = in_src_node[NODE_AW-1:0];
                src_nxt        = in_src_node[NODE_AW-1:0];
                state_nxt      = ST_LOAD;
              end
            end
            OP_RUN: begin
              div_req.start    = 1'b1;
              div_req.dividend = DIV_W'(BASE_W'(RANK_ONE) - BASE_W'(cfg_damp_r));
              div_req.divisor  = DSR_W'(n_cur);
              state_nxt        = ST_BASE_WAIT;
            end
            OP_READ: begin
              rank_raddr = in_dst_node[NODE_AW-1:0];
              rd_ok_nxt  = {1'b0, in_dst_node} < n_cur;
              state_nxt  = ST_READ;
            end
            OP_CLEAR: begin
              edge_total_nxt = '0;
              overflow_nxt   = 1'b0;
              v_nxt          = '0;
              state_nxt      = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      // bump the source degree, holding at its ceiling
      ST_LOAD: begin
        deg_we    = 1'b1;
        deg_waddr = src_r;
        deg_wdata = (deg_rdata == DEG_MAX) ? deg_rdata : deg_rdata + DEG_W'(1);
        state_nxt = ST_IDLE;
      end

      ST_READ: begin
        out_valid_nxt = 1'b1;
        out_rank_nxt  = rd_ok_r ? rank_rdata : '0;
        out_step_nxt  = sweep_cnt_r;
        out_conv_nxt  = last_conv_r;
        out_full_nxt  = overflow_r;
        state_nxt     = ST_IDLE;
      end

      ST_BASE_WAIT: begin
        if (div_rsp.done) begin
          base_nxt  = div_rsp.quotient[BASE_W-1:0];
          v_nxt     = '0;
          state_nxt = ST_INIT;
        end
      end

      ST_INIT: begin
        rank_we = 1'b1;
        v_nxt   = v_r + NODE_CNT_W'(1);
        if (v_last) begin
          v_nxt     = '0;
          steps_nxt = STEP_W'(1);
          state_nxt = ST_A_RD;
        end
      end

      // phase A: turn each rank into its per-edge share, clear the sum
      ST_A_RD: begin
        state_nxt = ST_A_DIV;
      end

      ST_A_DIV: begin
        if (v_idx == cfg_probe_r) begin
          last_nxt = rank_rdata;
        end
        if (deg_rdata == '0) begin
          rank_we    = 1'b1;
          rank_wdata = '0;
          sum_we     = 1'b1;
          v_nxt      = v_r + NODE_CNT_W'(1);
          state_nxt  = ST_A_RD;
          if (v_last) begin
            v_nxt     = '0;
            e_nxt     = '0;
            state_nxt = (edge_total_r == '0) ? ST_C_RD : ST_B_RD;
          end
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_A_WAIT;
        end
      end

      ST_A_WAIT: begin
        if (div_rsp.done) begin
          rank_we    = 1'b1;
          rank_wdata = div_rsp.quotient;
          sum_we     = 1'b1;
          v_nxt      = v_r + NODE_CNT_W'(1);
          state_nxt  = ST_A_RD;
          if (v_last) begin
            v_nxt     = '0;
            e_nxt     = '0;
            state_nxt = (edge_total_r == '0) ? ST_C_RD : ST_B_RD;
          end
        end
      end

      // phase B: B_RD, B_ADDR, B_WR per edge, so sum updates never overlap
      ST_B_RD: begin
        state_nxt = ST_B_ADDR;
      end

      ST_B_ADDR: begin
        rank_raddr = e_src;
        sum_raddr  = e_dst;
        t_nxt      = e_dst;
        skip_nxt   = ({1'b0, e_src} >= n_cur) || ({1'b0, e_dst} >= n_cur);
        state_nxt  = ST_B_WR;
      end

      ST_B_WR: begin
        sum_we    = !skip_r;
        sum_waddr = t_r;
        sum_wdata = acc_b[RANK_W] ? '1 : acc_b[RANK_W-1:0];
        e_nxt     = e_r + EDGE_CNT_W'(1);
        state_nxt = ST_B_RD;
        if (e_r == edge_total_r - EDGE_CNT_W'(1)) begin
          v_nxt     = '0;
          state_nxt = ST_C_RD;
        end
      end

      // phase C: rank = base + d * sum, saturated
      ST_C_RD: begin
        state_nxt = ST_C_MUL;
      end

      ST_C_MUL: begin
        prod_nxt  = PROD_W'(cfg_damp_r) * PROD_W'(sum_rdata);
        state_nxt = ST_C_WR;
      end

      ST_C_WR: begin
        rank_we    = 1'b1;
        rank_wdata = acc_c[RANK_W] ? '1 : acc_c[RANK_W-1:0];
        if (v_idx == cfg_probe_r) begin
          now_nxt = rank_wdata;
        end
        v_nxt     = v_r + NODE_CNT_W'(1);
        state_nxt = ST_C_RD;
        if (v_last) begin
          state_nxt = ST_CHK_MUL;
        end
      end

      ST_CHK_MUL: begin
        tolp_nxt  = PROD_W'(cfg_tol_r) * PROD_W'(last_r);
        diff_nxt  = (now_r > last_r) ? now_r - last_r : last_r - now_r;
        state_nxt = ST_CHK;
      end

      ST_CHK: begin
        if (conv || steps_r >= step_lim) begin
          sweep_cnt_nxt = steps_r;
          last_conv_nxt = conv;
          out_valid_nxt = 1'b1;
          out_rank_nxt  = probe_ok ? now_r : '0;
          out_step_nxt  = steps_r;
          out_conv_nxt  = conv;
          out_full_nxt  = overflow_r;
          state_nxt     = ST_IDLE;
        end else begin
          steps_nxt = steps_r + STEP_W'(1);
          v_nxt     = '0;
          state_nxt = ST_A_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_nodes_r <= RST_NODE_COUNT;
      cfg_damp_r  <= RST_DAMPING;
      cfg_tol_r   <= RST_TOLERANCE;
      cfg_probe_r <= RST_PROBE;
      cfg_max_r   <= RST_MAX_STEPS;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NODE_COUNT: cfg_nodes_r <= cfg_wdata[NODE_CNT_W-1:0];
        REG_DAMPING:    cfg_damp_r  <= cfg_wdata[Q16_W-1:0];
        REG_TOLERANCE:  cfg_tol_r   <= cfg_wdata[Q16_W-1:0];
        REG_PROBE:      cfg_probe_r <= cfg_wdata[NODE_AW-1:0];
        REG_MAX_STEPS:  cfg_max_r   <= cfg_wdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      v_r          <= '0;
      edge_total_r <= '0;
      overflow_r   <= 1'b0;
      sweep_cnt_r  <= '0;
      last_conv_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      v_r          <= v_nxt;
      edge_total_r <= edge_total_nxt;
      overflow_r   <= overflow_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      last_conv_r  <= last_conv_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    e_r        <= e_nxt;
    steps_r    <= steps_nxt;
    base_r     <= base_nxt;
    last_r     <= last_nxt;
    now_r      <= now_nxt;
    prod_r     <= prod_nxt;
    tolp_r     <= tolp_nxt;
    diff_r     <= diff_nxt;
    t_r        <= t_nxt;
    skip_r     <= skip_nxt;
    src_r      <= src_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_rank_r <= out_rank_nxt;
    out_step_r <= out_step_nxt;
    out_conv_r <= out_conv_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_strobe     = out_valid_r;
  assign out_rank_value = out_rank_r;
  assign out_step_count = out_step_r;
  assign out_converged  = out_conv_r;
  assign out_store_full = out_full_r;

  pre_ram #(.DEPTH(EDGE_DEPTH), .WIDTH(EDGE_DW)) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_raddr),
    .rdata (edge_rdata)
  );

  pre_ram #(.DEPTH(NODE_DEPTH), .WIDTH(DEG_W)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (deg_raddr),
    .rdata (deg_rdata)
  );

  pre_ram #(.DEPTH(NODE_DEPTH), .WIDTH(RANK_W)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (rank_wdata),
    .raddr (rank_raddr),
    .rdata (rank_rdata)
  );

  pre_ram #(.DEPTH(NODE_DEPTH), .WIDTH(RANK_W)) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  pre_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

// ----- sv/pre_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module pre_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/pre_div.sv -----
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, done pulses once all DIV_W bits are in.
// Depends on pre_pkg.
module pre_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pre_pkg::div_req_t req,
  output pre_pkg::div_rsp_t rsp
);
  import pre_pkg::*;

  localparam int CNT_W = $clog2(DIV_W);

  logic             active_r, active_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_W-1:0] dvd_r, dvd_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [DSR_W:0]   shifted;
  logic             fits;

  assign shifted = {rem_r, dvd_r[DIV_W-1]};
  assign fits    = shifted >= {1'b0, dsr_r};

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    dvd_nxt    = dvd_r;
    rem_nxt    = rem_r;
    dsr_nxt    = dsr_r;
    if (req.start) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      dvd_nxt    = req.dividend;
      rem_nxt    = '0;
      dsr_nxt    = req.divisor;
    end else if (active_r) begin
      // shift in one dividend bit, subtract when it fits
      rem_nxt = fits ? DSR_W'(shifted - {1'b0, dsr_r}) : shifted[DSR_W-1:0];
      dvd_nxt = {dvd_r[DIV_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIV_W - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule
